// ===== design/crbc_pkg.sv =====
`default_nettype none
package crbc_pkg;

   localparam logic [31:0] LcgMul = 32'd1664525;
   localparam logic [31:0] LcgAdd = 32'd1013904223;
   localparam int CfgIdxW = 3;
   localparam int DivCntW = 6;

   typedef enum logic [1:0] {
      OP_NEXT   = 2'd0,
      OP_REPORT = 2'd1,
      OP_LOST   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      M_START       = 3'd0,
      M_CONNECTING  = 3'd1,
      M_REGISTERING = 3'd2,
      M_AWAIT       = 3'd3,
      M_RUNNING     = 3'd4,
      M_BACKOFF     = 3'd5,
      M_STOPPED     = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      A_STOP     = 3'd0,
      A_WAIT     = 3'd1,
      A_CONNECT  = 3'd2,
      A_MAP      = 3'd3,
      A_REGISTER = 3'd4,
      A_SHOW     = 3'd5,
      A_POLL     = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      R_OK          = 3'd0,
      R_FATAL       = 3'd1,
      R_RATE        = 3'd2,
      R_TRANSPORT   = 3'd3,
      R_NEEDS_LOGIN = 3'd4,
      R_AUTH        = 3'd5
   } result_type;

   typedef enum logic [2:0] {
      CSR_SEED      = 3'd0,
      CSR_START_REG = 3'd1,
      CSR_BO_MIN    = 3'd2,
      CSR_BO_MAX    = 3'd3,
      CSR_RATE      = 3'd4,
      CSR_POLL      = 3'd5,
      CSR_TTL       = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_LCG,
      S_DIV,
      S_JITTER,
      S_OUT
   } fsm_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now_ms;
      logic [2:0]  reported_kind;
      logic [2:0]  result_code;
      logic [31:0] url_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] wait_ms;
      logic [31:0] login_tag;
      logic [2:0]  state_code;
      logic        is_connected;
      logic        is_registered;
      logic [31:0] attempt_count;
      logic [31:0] failure_count;
      logic [31:0] connect_count;
      logic [31:0] register_count;
      logic [31:0] map_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/crbc_if.sv =====
`default_nettype none
interface crbc_req_if;
   import crbc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface crbc_rsp_if;
   import crbc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/connect_retry_backoff_controller.sv =====
// session sequencer for a reconnecting client.
// req channel: one request carries op (next, report, lost), now_ms, the
// reported kind and result, and a login url tag. only a next request makes
// a rsp item: the action, wait time, login tag, the state and counters.
// csr port: write enable, index and 32-bit data, taken any cycle the block
// is idle; writing the seed, start flag or minimum backoff also reloads the
// related live state.
// sequence: every request is decided in S_DECIDE, and a next request then
// forms its rsp in S_OUT. a request that enters backoff with a base of 2
// or more goes on to S_LCG for the generator multiply, S_DIV, a 32-step
// restoring divider that forms the jitter remainder, and S_JITTER for the
// deadline.
// the block takes one request at a time; req_ready is low while it works
// and while a rsp waits. a stalled receiver holds rsp valid and data
// until taken.
// reset (synchronous) restores all but the request, rsp data and jitter
// registers: mode start, backoff base 1000 ms, seed 1 and all counters zero.
`default_nettype none
module connect_retry_backoff_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   crbc_req_if.sink         req,
   crbc_rsp_if.source       rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import crbc_pkg::*;

   fsm_type     st_ff, st_in;
   req_type     rq_ff, rq_in;
   rsp_type     out_ff, out_in;
   logic        rv_ff, rv_in;

   logic [31:0] seed_ff, seed_in;
   logic        sreg_ff, sreg_in;
   logic [29:0] bmin_ff, bmin_in;
   logic [30:0] bmax_ff, bmax_in;
   logic [30:0] rate_ff, rate_in;
   logic [30:0] poll_ff, poll_in;
   logic [31:0] ttl_ff, ttl_in;

   mode_type    mode_ff, mode_in;
   logic [31:0] bt_ff, bt_in, lcg_ff, lcg_in, dl_ff, dl_in;
   logic        regd_ff, regd_in, conn_ff, conn_in, uv_ff, uv_in, us_ff, us_in;
   logic [31:0] utag_ff, utag_in, utime_ff, utime_in;
   logic [31:0] att_ff, att_in, fail_ff, fail_in, cnt_ff, cnt_in;
   logic [31:0] regs_ff, regs_in, maps_ff, maps_in;

   // jitter unit
   logic [31:0] base_ff, base_in, rem_ff, rem_in, dvd_ff, dvd_in;
   logic [DivCntW-1:0] dc_ff, dc_in;
   logic        emit_ff, emit_in;

   logic [31:0] spread, trial_sh;
   logic [32:0] trial;

   assign spread = {1'b0, base_ff[31:1]};
   assign trial_sh = {rem_ff[30:0], dvd_ff[31]};
   assign trial = {1'b0, trial_sh} - {1'b0, spread};

   assign req.ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0;
         seed_ff <= 32'd1; sreg_ff <= 1'b0; bmin_ff <= 30'd1000;
         bmax_ff <= 31'd60000; rate_ff <= 31'd60000; poll_ff <= 31'd5000;
         ttl_ff <= 32'd600000;
         mode_ff <= M_START; bt_ff <= 32'd1000; lcg_ff <= 32'd1; dl_ff <= '0;
         regd_ff <= 1'b0; conn_ff <= 1'b0; uv_ff <= 1'b0; us_ff <= 1'b0;
         utag_ff <= '0; utime_ff <= '0; att_ff <= '0; fail_ff <= '0;
         cnt_ff <= '0; regs_ff <= '0; maps_ff <= '0; emit_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in;
         seed_ff <= seed_in; sreg_ff <= sreg_in; bmin_ff <= bmin_in;
         bmax_ff <= bmax_in; rate_ff <= rate_in; poll_ff <= poll_in;
         ttl_ff <= ttl_in;
         mode_ff <= mode_in; bt_ff <= bt_in; lcg_ff <= lcg_in; dl_ff <= dl_in;
         regd_ff <= regd_in; conn_ff <= conn_in; uv_ff <= uv_in; us_ff <= us_in;
         utag_ff <= utag_in; utime_ff <= utime_in; att_ff <= att_in;
         fail_ff <= fail_in; cnt_ff <= cnt_in; regs_ff <= regs_in;
         maps_ff <= maps_in; emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in; out_ff <= out_in;
      base_ff <= base_in; rem_ff <= rem_in; dvd_ff <= dvd_in; dc_ff <= dc_in;
   end

   always_comb begin
      logic [31:0] bt2;
      logic [31:0] base;
      logic        jit;
      logic        dobo;
      logic        nxt;
      st_in = st_ff; rv_in = rv_ff; rq_in = rq_ff; out_in = out_ff;
      seed_in = seed_ff; sreg_in = sreg_ff; bmin_in = bmin_ff; bmax_in = bmax_ff;
      rate_in = rate_ff; poll_in = poll_ff; ttl_in = ttl_ff;
      mode_in = mode_ff; bt_in = bt_ff; lcg_in = lcg_ff; dl_in = dl_ff;
      regd_in = regd_ff; conn_in = conn_ff; uv_in = uv_ff; us_in = us_ff;
      utag_in = utag_ff; utime_in = utime_ff; att_in = att_ff; fail_in = fail_ff;
      cnt_in = cnt_ff; regs_in = regs_ff; maps_in = maps_ff;
      base_in = base_ff; rem_in = rem_ff; dvd_in = dvd_ff; dc_in = dc_ff;
      emit_in = emit_ff;
      base = bt_ff; jit = 1'b0; dobo = 1'b0; nxt = 1'b0;
      bt2 = '0;

      if (rv_ff && rsp.ready) rv_in = 1'b0;

      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SEED: begin
               seed_in = csr_wdata;
               lcg_in = (csr_wdata == '0) ? 32'd1 : csr_wdata;
            end
            CSR_START_REG: begin
               sreg_in = csr_wdata[0]; regd_in = csr_wdata[0];
            end
            CSR_BO_MIN: begin
               bmin_in = csr_wdata[29:0]; bt_in = {2'b00, csr_wdata[29:0]};
            end
            CSR_BO_MAX: bmax_in = csr_wdata[30:0];
            CSR_RATE:   rate_in = csr_wdata[30:0];
            CSR_POLL:   poll_in = csr_wdata[30:0];
            CSR_TTL:    ttl_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (st_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               rq_in = req.data;
               st_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            out_in = '0;
            out_in.action = A_STOP;
            emit_in = 1'b0;
            if (rq_ff.op == OP_NEXT) begin
               nxt = 1'b1;
               emit_in = 1'b1;
               unique case (mode_ff)
                  M_STOPPED: ;
                  M_BACKOFF: begin
                     if (rq_ff.now_ms - dl_ff >= 32'h8000_0000) begin
                        out_in.action = A_WAIT; out_in.wait_ms = dl_ff - rq_ff.now_ms;
                     end else begin
                        mode_in = M_CONNECTING; out_in.action = A_CONNECT;
                     end
                  end
                  M_CONNECTING: begin
                     if (regd_ff) begin
                        mode_in = M_RUNNING; out_in.action = A_MAP;
                     end else begin
                        mode_in = M_REGISTERING; out_in.action = A_REGISTER;
                     end
                  end
                  M_REGISTERING: out_in.action = A_REGISTER;
                  M_AWAIT: begin
                     priority if (!uv_ff) begin
                        mode_in = M_REGISTERING; out_in.action = A_REGISTER;
                     end else if (!us_ff) begin
                        us_in = 1'b1; out_in.action = A_SHOW;
                        out_in.login_tag = utag_ff;
                     end else if (rq_ff.now_ms - utime_ff > ttl_ff) begin
                        uv_in = 1'b0; us_in = 1'b0;
                        mode_in = M_REGISTERING; out_in.action = A_REGISTER;
                     end else if (rq_ff.now_ms - dl_ff >= 32'h8000_0000) begin
                        out_in.action = A_WAIT; out_in.wait_ms = dl_ff - rq_ff.now_ms;
                     end else begin
                        out_in.action = A_POLL; out_in.login_tag = utag_ff;
                     end
                  end
                  M_RUNNING: out_in.action = A_MAP;
                  default: begin
                     mode_in = M_CONNECTING; out_in.action = A_CONNECT;
                  end
               endcase
            end else if (rq_ff.op == OP_LOST && mode_ff != M_STOPPED) begin
               conn_in = 1'b0;
               if (mode_ff == M_RUNNING) begin
                  base = {2'b00, bmin_ff};
                  bt_in = {2'b00, bmin_ff};
                  att_in = '0;
               end
               dobo = 1'b1;
            end else if (rq_ff.op == OP_REPORT && mode_ff != M_STOPPED) begin
               priority if (rq_ff.result_code == R_FATAL) begin
                  mode_in = M_STOPPED; fail_in = fail_ff + 32'd1;
               end else if (rq_ff.result_code == R_RATE) begin
                  base = {1'b0, rate_ff}; dobo = 1'b1;
               end else if (rq_ff.result_code == R_TRANSPORT) begin
                  dobo = 1'b1;
               end else if (rq_ff.reported_kind == A_CONNECT) begin
                  if (rq_ff.result_code == R_OK) begin
                     conn_in = 1'b1; cnt_in = cnt_ff + 32'd1;
                     bt_in = {2'b00, bmin_ff}; att_in = '0;
                  end else dobo = 1'b1;
               end else if (rq_ff.reported_kind == A_REGISTER ||
                            rq_ff.reported_kind == A_POLL) begin
                  if (rq_ff.result_code == R_OK) begin
                     regd_in = 1'b1; uv_in = 1'b0; us_in = 1'b0;
                     regs_in = regs_ff + 32'd1; bt_in = {2'b00, bmin_ff};
                     att_in = '0; mode_in = M_RUNNING;
                  end else if (rq_ff.result_code == R_NEEDS_LOGIN) begin
                     if (rq_ff.url_tag != '0 && rq_ff.url_tag != utag_ff) begin
                        utag_in = rq_ff.url_tag; utime_in = rq_ff.now_ms;
                        uv_in = 1'b1; us_in = 1'b0;
                     end
                     mode_in = M_AWAIT;
                     dl_in = rq_ff.now_ms + {1'b0, poll_ff};
                  end else if (rq_ff.result_code == R_AUTH) begin
                     regd_in = 1'b0; uv_in = 1'b0; us_in = 1'b0; dobo = 1'b1;
                  end
               end else if (rq_ff.reported_kind == A_MAP) begin
                  if (rq_ff.result_code == R_OK) begin
                     maps_in = maps_ff + 32'd1;
                     bt_in = {2'b00, bmin_ff}; att_in = '0;
                     mode_in = M_BACKOFF; conn_in = 1'b0;
                     base = {2'b00, bmin_ff}; jit = 1'b1;
                  end else begin
                     if (rq_ff.result_code == R_AUTH) regd_in = 1'b0;
                     dobo = 1'b1;
                  end
               end
            end

            if (dobo) begin
               mode_in = M_BACKOFF; conn_in = 1'b0;
               att_in = ((mode_ff == M_RUNNING && rq_ff.op == OP_LOST) ? 32'd0 : att_ff)
                        + 32'd1;
               fail_in = fail_ff + 32'd1;
               jit = 1'b1;
               // lost from running doubles the freshly cleared base
               if (rq_ff.op == OP_LOST && mode_ff == M_RUNNING) bt2 = {2'b00, bmin_ff};
               else bt2 = bt_ff;
               if (bt2 < {1'b0, bmax_ff}) begin
                  bt2 = {bt2[30:0], 1'b0};
                  if (bt2 > {1'b0, bmax_ff}) bt2 = {1'b0, bmax_ff};
               end
               bt_in = bt2;
               if (rq_ff.op == OP_REPORT && rq_ff.result_code == R_RATE)
                  bt_in = {1'b0, bmax_ff};
            end

            base_in = base;
            if (jit) begin
               if (base[31:1] == '0) begin
                  dl_in = rq_ff.now_ms + base;
                  st_in = S_IDLE;
               end else st_in = S_LCG;
            end else if (nxt) st_in = S_OUT;
            else st_in = S_IDLE;
         end
         S_LCG: begin
            lcg_in = lcg_ff * LcgMul + LcgAdd;
            st_in = S_DIV;
            rem_in = '0;
            dc_in = '0;
         end
         S_DIV: begin
            if (dc_ff == '0) dvd_in = {8'h00, lcg_ff[31:8]};
            // restoring divider, one bit per cycle
            if (dc_ff != '0) begin
               if (!trial[32]) rem_in = trial[31:0];
               else rem_in = trial_sh;
               dvd_in = {dvd_ff[30:0], 1'b0};
            end
            dc_in = dc_ff + 1'b1;
            if (dc_ff == DivCntW'(32)) st_in = S_JITTER;
         end
         S_JITTER: begin
            dl_in = rq_ff.now_ms + base_ff - {1'b0, spread[31:1]} + rem_ff;
            st_in = S_IDLE;
         end
         S_OUT: begin
            out_in.state_code = mode_ff;
            out_in.is_connected = conn_ff;
            out_in.is_registered = regd_ff;
            out_in.attempt_count = att_ff;
            out_in.failure_count = fail_ff;
            out_in.connect_count = cnt_ff;
            out_in.register_count = regs_ff;
            out_in.map_count = maps_ff;
            rv_in = emit_ff;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   logic unused_ok;
   assign unused_ok = ^{seed_ff, sreg_ff};
endmodule
`default_nettype wire

// ===== design/crbc_check.sv =====
`default_nettype none
module crbc_check (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_action,
   input wire logic [31:0] rsp_wait
);
   import crbc_pkg::*;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after request");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while rsp pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("rsp dropped");
   a_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != A_WAIT) |-> rsp_wait == '0) else $error("stray wait");
endmodule

bind connect_retry_backoff_controller crbc_check u_check (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_action(rsp.data.action),
   .rsp_wait(rsp.data.wait_ms)
);
`default_nettype wire
